// ----- rtl/bbw_pkg.sv -----
`timescale 1ns / 1ps

package bbw_pkg;

	// block limits and fixed field widths
	localparam int MAX_TAPS         = 31;
	localparam int WEIGHT_FRAC_BITS = 24;
	localparam int OFS_FRAC_BITS    = 16;
	localparam int OFS_W            = 22;
	localparam int TAP_W            = 5;

	// derived sizes
	localparam int N_MAX    = MAX_TAPS + 3;
	localparam int HALF_MAX = N_MAX / 2;
	localparam int ROW_W    = N_MAX;
	localparam int DIV_W    = N_MAX + 1;
	localparam int R_W      = $clog2(N_MAX + 1);
	localparam int IDX_W    = $clog2(HALF_MAX + 1);
	localparam int SAT_W    = (R_W > TAP_W) ? R_W : TAP_W;
	localparam int P_MAX    = ((MAX_TAPS + 1) / 2 - 1) / 2;
	localparam int J_W      = $clog2(P_MAX + 2);
	localparam int Q_W      = ((WEIGHT_FRAC_BITS > OFS_FRAC_BITS) ?
	                           WEIGHT_FRAC_BITS : OFS_FRAC_BITS) + 2;
	localparam int CNT_W    = $clog2(Q_W + 1);

	// iterations of the divider: one integer step, the fraction steps and one rounding step
	localparam int W_STEPS = WEIGHT_FRAC_BITS + 2;
	localparam int O_STEPS = OFS_FRAC_BITS + 2;

	typedef struct packed {
		logic busy;
		logic done;
		logic rem_nz;
	} div_stat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} row_stat_t;

endpackage

// ----- rtl/bbw_div.sv -----
`timescale 1ns / 1ps

// restoring shift-subtract divider, one quotient bit per cycle
// first step compares without shifting (integer bit), num must be below 2*den
module bbw_div
	import bbw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	input  logic [CNT_W-1:0] steps,
	output logic [Q_W-1:0]   quo,
	output div_stat_t        stat
);

	logic             busy_q;
	logic             done_q;
	logic             first_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [Q_W-1:0]   quo_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             ge;
	logic [DIV_W-1:0] rem_next;

	always_comb begin
		trial    = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
		diff     = trial - {1'b0, den_q};
		ge       = trial >= {1'b0, den_q};
		rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= steps;
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign quo         = quo_q;
	assign stat.busy   = busy_q;
	assign stat.done   = done_q;
	assign stat.rem_nz = |rem_q;

endmodule

// ----- rtl/bbw_row.sv -----
`timescale 1ns / 1ps

// pascal row builder, lower half only, one add per cycle
module bbw_row
	import bbw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [R_W-1:0]   n,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [ROW_W-1:0] rd_data,
	output row_stat_t        stat
);

	logic [ROW_W-1:0] row_q [0:HALF_MAX];
	logic [ROW_W-1:0] prev_q;
	logic [R_W-1:0]   r_q;
	logic [IDX_W-1:0] k_q;
	logic             busy_q;
	logic             done_q;

	logic [IDX_W-1:0] addr;
	logic [IDX_W-1:0] k_end;
	logic [ROW_W-1:0] cur;
	logic             row_end;

	always_comb begin
		addr    = busy_q ? k_q : rd_idx;
		rd_data = row_q[addr];
		k_end   = (r_q < R_W'(HALF_MAX)) ? IDX_W'(r_q) : IDX_W'(HALF_MAX);
		// entry at the top of the current row was zero in the previous row
		cur     = (R_W'(k_q) == r_q) ? '0 : rd_data;
		row_end = (k_q == k_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			r_q    <= '0;
			k_q    <= '0;
		end else begin
			done_q <= !start && busy_q && row_end && (r_q == n);
			if (start) begin
				busy_q <= 1'b1;
				r_q    <= R_W'(1);
				k_q    <= IDX_W'(1);
			end else if (busy_q) begin
				if (row_end) begin
					k_q <= IDX_W'(1);
					if (r_q == n) begin
						busy_q <= 1'b0;
					end else begin
						r_q <= r_q + R_W'(1);
					end
				end else begin
					k_q <= k_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prev_q <= ROW_W'(1);
		end else if (busy_q) begin
			row_q[k_q] <= cur + prev_q;
			prev_q     <= row_end ? ROW_W'(1) : cur;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- rtl/binomial_blur_weight_generator.sv -----
`timescale 1ns / 1ps

// binomial blur weight generator, linear-sampling form
//
// input channel: tap_count with in_valid / in_stall. an item is taken when
// in_valid is high and in_stall low; in_stall stays high until the last
// result of the table has been loaded into the output register.
// output channel: tap_weight (Q0.24, saturated), tap_offset (Q6.16) and last,
// with out_valid / out_stall. one to p+1 results per item, last marks the end.
// the pascal row is built first; then the center result takes one row read
// and a weight division, and each pair takes two row reads, a weight
// division and an offset division. a new item is taken only once the
// last result of the table has been loaded into the output register.
// a zero tap count gives a single all-zero result with last set.
// out_stall holds the result in the output register; the sequencer waits
// for it to drain before loading the next one.
// reset clears the sequencer and the output valid; no table is pending.
module binomial_blur_weight_generator
	import bbw_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [TAP_W-1:0]            tap_count,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [WEIGHT_FRAC_BITS-1:0] tap_weight,
	output logic [OFS_W-1:0]            tap_offset,
	output logic                        last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_RD1,
		ST_RD2,
		ST_WDIV,
		ST_ODIV,
		ST_EMIT
	} state_t;

	localparam int FL_W = OFS_W + 1;

	state_t                      state_q;
	logic                        row_start_q;
	logic                        div_start_q;
	logic                        out_valid_q;
	logic [R_W-1:0]              n_q;
	logic [IDX_W-1:0]            h_q;
	logic [J_W-1:0]              p_q;
	logic [J_W-1:0]              j_q;

	// payload registers
	logic [DIV_W-1:0]            den_q;
	logic [ROW_W-1:0]            c1_q;
	logic [ROW_W-1:0]            c2_q;
	logic [WEIGHT_FRAC_BITS-1:0] w_q;
	logic [OFS_W-1:0]            o_q;
	logic [WEIGHT_FRAC_BITS-1:0] tap_weight_q;
	logic [OFS_W-1:0]            tap_offset_q;
	logic                        last_q;

	// input decode
	logic [SAT_W-1:0]            s_ext;
	logic [SAT_W-1:0]            s_sat;
	logic [R_W-1:0]              n_next;
	logic [SAT_W-1:0]            m_next;
	logic                        s_zero;

	logic                        accept;
	logic                        out_free;

	// unit hookup
	logic [IDX_W-1:0]            rd_idx;
	logic [ROW_W-1:0]            rd_data;
	row_stat_t                   row_stat;
	logic [DIV_W-1:0]            csum;
	logic [DIV_W-1:0]            div_num;
	logic [DIV_W-1:0]            div_den;
	logic [CNT_W-1:0]            div_steps;
	logic [Q_W-1:0]              div_quo;
	div_stat_t                   div_stat;

	// result shaping
	logic [Q_W:0]                wq_p1;
	logic [WEIGHT_FRAC_BITS:0]   w_round;
	logic [WEIGHT_FRAC_BITS-1:0] w_sat;
	logic [FL_W-1:0]             fl;
	logic [FL_W-1:0]             fl_p1;

	always_comb begin
		s_ext  = SAT_W'(tap_count);
		s_sat  = (s_ext > SAT_W'(MAX_TAPS)) ? SAT_W'(MAX_TAPS) : s_ext;
		s_zero = (s_ext == '0);
		n_next = R_W'(s_sat + SAT_W'(3));
		m_next = (s_sat + SAT_W'(1)) >> 1;
		accept = in_valid && (state_q == ST_IDLE);
		out_free = !out_valid_q || !out_stall;
	end

	// row addresses of the two binomials of pair j (j = 0 reads the center)
	always_comb begin
		if (state_q == ST_RD1) begin
			rd_idx = h_q - (IDX_W'(j_q) << 1) + IDX_W'(1);
		end else begin
			rd_idx = h_q - (IDX_W'(j_q) << 1);
		end
	end

	// divider operands: weight pass over den, offset pass over the pair sum
	always_comb begin
		csum = DIV_W'(c1_q) + DIV_W'(c2_q);
		if (state_q == ST_ODIV) begin
			div_num   = DIV_W'(c1_q);
			div_den   = csum;
			div_steps = CNT_W'(O_STEPS);
		end else begin
			div_num   = csum;
			div_den   = den_q;
			div_steps = CNT_W'(W_STEPS);
		end
	end

	// round half up, saturate at all ones; offset = 2j - c1/(c1+c2)
	always_comb begin
		wq_p1   = {1'b0, div_quo} + (Q_W + 1)'(1);
		w_round = wq_p1[WEIGHT_FRAC_BITS+1:1];
		w_sat   = w_round[WEIGHT_FRAC_BITS] ? '1 : w_round[WEIGHT_FRAC_BITS-1:0];
		fl      = (FL_W'(j_q) << (OFS_FRAC_BITS + 2)) - FL_W'(div_quo)
		        - FL_W'(div_stat.rem_nz);
		fl_p1   = fl + FL_W'(1);
	end

	bbw_row u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (row_start_q),
		.n       (n_q),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.stat    (row_stat)
	);

	bbw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (div_num),
		.den    (div_den),
		.steps  (div_steps),
		.quo    (div_quo),
		.stat   (div_stat)
	);

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			n_q         <= '0;
			h_q         <= '0;
			p_q         <= '0;
			j_q         <= '0;
		end else begin
			// one-cycle start pulses for the row builder and the divider
			row_start_q <= accept && !s_zero;
			div_start_q <= (state_q == ST_RD2) ||
			               (state_q == ST_WDIV && div_stat.done && j_q != '0);
			// valid is set on a load and held while the receiver stalls
			out_valid_q <= (state_q == ST_EMIT && out_free) ||
			               (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						j_q <= '0;
						if (s_zero) begin
							p_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							n_q     <= n_next;
							h_q     <= IDX_W'(n_next >> 1);
							p_q     <= J_W'((m_next - SAT_W'(1)) >> 1);
							state_q <= ST_ROW;
						end
					end
				end
				ST_ROW: begin
					if (row_stat.done) begin
						state_q <= ST_RD2;
					end
				end
				ST_RD1: begin
					state_q <= ST_RD2;
				end
				ST_RD2: begin
					state_q <= ST_WDIV;
				end
				ST_WDIV: begin
					if (div_stat.done) begin
						if (j_q == '0) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_ODIV;
						end
					end
				end
				ST_ODIV: begin
					if (div_stat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (j_q == p_q) begin
							state_q <= ST_IDLE;
						end else begin
							j_q     <= j_q + J_W'(1);
							state_q <= ST_RD1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working values and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			den_q <= (DIV_W'(1) << n_next) - (DIV_W'(n_next) << 1) - DIV_W'(2);
			w_q   <= '0;
			o_q   <= '0;
		end
		if (state_q == ST_RD1) begin
			c1_q <= rd_data;
		end
		if (state_q == ST_RD2) begin
			c2_q <= rd_data;
			if (j_q == '0) begin
				c1_q <= '0;
			end
		end
		if (state_q == ST_WDIV && div_stat.done) begin
			w_q <= w_sat;
			o_q <= '0;
		end
		if (state_q == ST_ODIV && div_stat.done) begin
			o_q <= fl_p1[FL_W-1:1];
		end
		if (state_q == ST_EMIT && out_free) begin
			tap_weight_q <= w_q;
			tap_offset_q <= o_q;
			last_q       <= (j_q == p_q);
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign tap_weight = tap_weight_q;
	assign tap_offset = tap_offset_q;
	assign last       = last_q;

	// a taken item closes the input until its table is out
	a_stall_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not closed after an item was taken");

	// row builder and divider never run at the same time
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(row_stat.busy && div_stat.busy))
		else $error("row builder and divider busy together");

	// divider results only arrive while the sequencer waits for them
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_WDIV || state_q == ST_ODIV))
		else $error("divider finished outside a division state");

	// row completion only while the sequencer waits for the row
	a_row_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		row_stat.done |-> (state_q == ST_ROW))
		else $error("row builder finished outside the row state");

endmodule
